FILE: sv/sdq_pkg.sv
// Shared constants, types and helpers for the searchable deque with running average.
package sdq_pkg;

  // Ring buffer depth; kept a power of two so that pointers wrap by truncation.
  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int SUM_W  = 40;
  localparam int POS_W  = 8;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_DIGIT_W = 4;

  typedef enum logic [1:0] {
    MODE_PUSH      = 2'd0,
    MODE_POP_FRONT = 2'd1,
    MODE_POP_REAR  = 2'd2,
    MODE_SEARCH    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // Request to the mean divider.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  // Answer from the mean divider.
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } div_rsp_t;

  // Sign-extends a stored value to the width of the running sum.
  function automatic logic signed [SUM_W-1:0] sext_value(input logic signed [DATA_W-1:0] v);
    sext_value = {{(SUM_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

FILE: sv/sdq_req_if.sv
// Request channel: operation mode and operand value.
interface sdq_req_if
  import sdq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  mode_t                    mode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

FILE: sv/sdq_rsp_if.sv
// Response channel: status, match position, entry count and mean.
interface sdq_rsp_if
  import sdq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         entry_count;
  logic signed [DATA_W-1:0] mean_value;

  modport source (output valid, output status, output found_position, output entry_count,
                  output mean_value, input ready);
  modport sink   (input valid, input status, input found_position, input entry_count,
                  input mean_value, output ready);
endinterface

FILE: sv/sdq_div.sv
// Iterative signed-by-unsigned divider for the mean, four quotient bits per cycle.
module sdq_div
  import sdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DIV_STEPS = SUM_W / DIV_DIGIT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     rem_next;
  logic [SUM_W-1:0]     quo_next;
  logic [SUM_W-1:0]     quo_signed;

  // Restoring division over one digit: the remainder stays below the divisor.
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [SUM_W-1:0] q;
    logic [CNT_W:0]   t;
    r = rem;
    q = quo;
    for (int k = 0; k < DIV_DIGIT_W; k++) begin
      t = {r, q[SUM_W-1]};
      q = {q[SUM_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        r    = CNT_W'(t - {1'b0, dvs});
        q[0] = 1'b1;
      end else begin
        r = t[CNT_W-1:0];
      end
    end
    rem_next = r;
    quo_next = q;
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend magnitude shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[SUM_W-1];
      quo <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // Truncation toward zero: negate the magnitude quotient for a negative sum.
  assign quo_signed   = neg ? SUM_W'(-quo) : quo;
  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[DATA_W-1:0];

endmodule

FILE: sv/searchable_deque_with_average.sv
// Top level of the searchable deque with running average.
// A bounded deque of 256 signed 32-bit values in a synchronous RAM with separate
// write and read ports, with a 40-bit running sum, one response per request.
// Items are taken one at a time; a new request is accepted while the previous
// response still waits in the output register. A push goes to the radix-16 mean
// divider; either removal first reads the removed entry from the RAM, and a
// search reads one entry per cycle from the RAM until a match or the last entry,
// before the division. A removal or a search on an empty queue, and a removal
// that empties the queue, skip the divider, since no division is needed then. A
// finished response that finds the output register still occupied waits until
// that register is free. The RAM needs no clearing after reset, since the data
// of unoccupied entries is never used.
module searchable_deque_with_average
  import sdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sdq_req_if.sink   req,
  sdq_rsp_if.source rsp
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_POP    = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_MEAN   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t                   state;
  logic [ADDR_W-1:0]        head;
  logic [CNT_W-1:0]         occ;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         occ_m1;
  logic                     accept;
  logic                     full;

  mode_t                    cur_mode;
  logic signed [DATA_W-1:0] cur_value;
  status_t                  res_status;
  logic [ADDR_W-1:0]        res_pos;
  logic [ADDR_W-1:0]        scan_idx;
  logic signed [DATA_W-1:0] mean;
  logic                     hit;
  logic                     last;
  logic                     out_valid;
  logic                     out_load;

  logic [DATA_W-1:0]        mem [DEPTH];
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign full      = (occ == CNT_W'(DEPTH));
  assign occ_m1    = occ - 1'b1;
  assign hit       = (rd_data == cur_value);
  assign last      = ({1'b0, scan_idx} == occ_m1);
  assign out_load  = (state == ST_DONE) && (!out_valid || rsp.ready);

  // RAM port control. Writes happen only on a push transfer and reads only for
  // later work, so a write and a read of the same entry never meet in one cycle.
  assign wr_en   = accept && (req.mode == MODE_PUSH) && !full;
  assign wr_addr = head + occ[ADDR_W-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (accept) begin
      unique case (req.mode)
        MODE_POP_FRONT: rd_en = 1'b1;
        MODE_POP_REAR: begin
          rd_en   = 1'b1;
          rd_addr = head + occ_m1[ADDR_W-1:0];
        end
        MODE_SEARCH:    rd_en = 1'b1;
        default:        rd_en = 1'b0;
      endcase
    end else if (state == ST_SEARCH) begin
      // Prefetch the entry after the one now being compared.
      rd_en   = 1'b1;
      rd_addr = head + scan_idx + 1'b1;
    end
  end

  // Entry store with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer and queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      occ       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register holds a response until its transfer.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.mode)
              MODE_PUSH: begin
                if (!full) begin
                  occ <= occ + 1'b1;
                  sum <= sum + sext_value(req.value);
                end
                state <= ST_MEAN;
              end
              MODE_POP_FRONT, MODE_POP_REAR: state <= (occ == '0) ? ST_MEAN : ST_POP;
              MODE_SEARCH:                   state <= (occ == '0) ? ST_MEAN : ST_SEARCH;
              default:                       state <= ST_MEAN;
            endcase
          end
        end
        ST_POP: begin
          sum <= sum - sext_value(rd_data);
          occ <= occ_m1;
          if (cur_mode == MODE_POP_FRONT) begin
            head <= head + 1'b1;
          end
          state <= ST_MEAN;
        end
        ST_SEARCH: begin
          if (hit || last) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          state <= (occ == '0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-request results and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode  <= req.mode;
      cur_value <= req.value;
      res_pos   <= '0;
      scan_idx  <= '0;
      priority if (req.mode == MODE_PUSH && full) begin
        res_status <= STAT_FULL;
      end else if ((req.mode == MODE_POP_FRONT || req.mode == MODE_POP_REAR) && occ == '0) begin
        res_status <= STAT_EMPTY;
      end else if (req.mode == MODE_SEARCH && occ == '0) begin
        res_status <= STAT_NOT_FOUND;
      end else begin
        res_status <= STAT_OK;
      end
    end
    if (state == ST_SEARCH) begin
      priority if (hit) begin
        res_pos <= scan_idx;
      end else if (last) begin
        res_status <= STAT_NOT_FOUND;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (state == ST_MEAN && occ == '0) begin
      mean <= '0;
    end
    if (state == ST_DIV && div_rsp.done) begin
      mean <= div_rsp.quotient;
    end
    if (out_load) begin
      rsp.status         <= res_status;
      rsp.found_position <= POS_W'(res_pos);
      rsp.entry_count    <= occ;
      rsp.mean_value     <= mean;
    end
  end

  assign rsp.valid = out_valid;

  // Mean of the contents after the update.
  assign div_req.start    = (state == ST_MEAN) && (occ != '0);
  assign div_req.dividend = sum;
  assign div_req.divisor  = occ;

  sdq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

FILE: sv/sdq_checker.sv
// Port-level checks on the searchable deque responses, bound to the top level.
module sdq_checker
  import sdq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input status_t                  rsp_status,
  input logic [POS_W-1:0]         rsp_found_position,
  input logic [CNT_W-1:0]         rsp_entry_count,
  input logic signed [DATA_W-1:0] rsp_mean_value
);

  // A pending response is held until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))
    else $error("response dropped or changed before transfer");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // A removal from an empty queue leaves it empty with zero mean.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_EMPTY |-> rsp_entry_count == '0 && rsp_mean_value == '0)
    else $error("empty status with nonzero count or mean");

  // A rejected push is reported only when the queue is at capacity.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_count == CNT_W'(DEPTH))
    else $error("full status below capacity");

  // Only a successful search can report a nonzero position.
  a_position: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_OK |-> rsp_found_position == '0)
    else $error("position reported without a match");

endmodule

bind searchable_deque_with_average sdq_checker u_sdq_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_entry_count    (rsp.entry_count),
  .rsp_mean_value     (rsp.mean_value)
);
